// ===== design/simd_mi_pkg.sv =====
// ----------------------------------------------------------------------------
// simd_mi_pkg
// Shared types and constants for the SIMD modified-immediate execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package simd_mi_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned RegW  = 5;

    typedef enum logic [1:0] {
        KIND_VMOV = 2'd0,
        KIND_VMVN = 2'd1,
        KIND_VORR = 2'd2,
        KIND_VBIC = 2'd3
    } t_kind;

    // decoded control word, already forced to zero where undefined
    typedef struct packed {
        logic            undef;
        t_kind           kind;
        logic [RegW-1:0] first_index;
        logic            second_valid;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/simd_mi_expand.sv =====
// ----------------------------------------------------------------------------
// simd_mi_expand
// Decodes cmode/op into the operation and expands imm8 into the 64-bit
// immediate (replicated, ones-filled, byte mask and float forms).
// ----------------------------------------------------------------------------
`default_nettype none

module simd_mi_expand
    import simd_mi_pkg::*;
(
    input  wire logic [7:0]       i_imm_byte,
    input  wire logic [3:0]       i_cmode,
    input  wire logic             i_op_bit,
    input  wire logic             i_quad,
    input  wire logic [3:0]       i_vd_field,
    input  wire logic             i_d_high,
    output t_ctl                  o_ctl,
    output logic [DataW-1:0]      o_imm
);

    logic        undef;
    t_kind       kind;
    logic [31:0] w32;
    logic [15:0] w16;
    logic [63:0] mask;

    always_comb begin
        undef = (i_quad && i_vd_field[0]) || ((i_cmode == 4'hF) && i_op_bit);

        if (i_cmode >= 4'd12) begin
            kind = (i_op_bit && (i_cmode <= 4'd13)) ? KIND_VMVN : KIND_VMOV;
        end else if (!i_cmode[0]) begin
            kind = i_op_bit ? KIND_VMVN : KIND_VMOV;
        end else begin
            kind = i_op_bit ? KIND_VBIC : KIND_VORR;
        end

        o_ctl.undef        = undef;
        o_ctl.kind         = undef ? KIND_VMOV : kind;
        o_ctl.first_index  = undef ? '0 : {i_d_high, i_vd_field};
        o_ctl.second_valid = i_quad && !undef;
    end

    // per-bit byte mask: each immediate bit fills one byte
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask[8*i +: 8] = {8{i_imm_byte[i]}};
        end
    end

    always_comb begin
        w32   = '0;
        w16   = '0;
        o_imm = '0;
        unique case (i_cmode[3:1])
            3'd0: begin
                w32   = {24'h0, i_imm_byte};
                o_imm = {w32, w32};
            end
            3'd1: begin
                w32   = {16'h0, i_imm_byte, 8'h0};
                o_imm = {w32, w32};
            end
            3'd2: begin
                w32   = {8'h0, i_imm_byte, 16'h0};
                o_imm = {w32, w32};
            end
            3'd3: begin
                w32   = {i_imm_byte, 24'h0};
                o_imm = {w32, w32};
            end
            3'd4: begin
                w16   = {8'h0, i_imm_byte};
                o_imm = {4{w16}};
            end
            3'd5: begin
                w16   = {i_imm_byte, 8'h0};
                o_imm = {4{w16}};
            end
            3'd6: begin
                w32   = i_cmode[0] ? {8'h0, i_imm_byte, 16'hFFFF}
                                   : {16'h0, i_imm_byte, 8'hFF};
                o_imm = {w32, w32};
            end
            3'd7: begin
                priority if (!i_cmode[0] && !i_op_bit) begin
                    o_imm = {8{i_imm_byte}};
                end else if (!i_cmode[0]) begin
                    o_imm = mask;
                end else if (!i_op_bit) begin
                    // single-precision: sign, NOT(b), b x5, cdefgh, zeros
                    w32   = {i_imm_byte[7], ~i_imm_byte[6], {5{i_imm_byte[6]}},
                             i_imm_byte[5:0], 19'h0};
                    o_imm = {w32, w32};
                end else begin
                    // double-precision form
                    o_imm = {i_imm_byte[7], ~i_imm_byte[6], {8{i_imm_byte[6]}},
                             i_imm_byte[5:0], 48'h0};
                end
            end
            default: o_imm = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/simd_modified_immediate_execute.sv =====
// ----------------------------------------------------------------------------
// simd_modified_immediate_execute
// Execute unit for the Advanced SIMD one-register modified-immediate group
// (VMOV, VMVN, VORR, VBIC): immediate expansion and register update.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive the instruction fields and the current D register contents
//    and raise start; the word is taken at a clock edge with start high and
//    busy low. busy is tied low: the unit takes a word every cycle.
//  - Output: o_strobe is high for exactly one cycle per input word, with the
//    result fields valid in that cycle. There is no back-pressure; the
//    receiver must take the word when it is strobed.
//  - Pipeline: three register stages (input capture, decode/expand,
//    combine) lie between accept and strobe. Throughput one word per
//    cycle; results leave in the order the words came in.
//  - Undefined encodings (Q with odd Vd, cmode 1111 with op 1) give a word
//    with o_undefined high and every other field zero.
//  - Reset (synchronous, active low) clears the stage valid bits, so no
//    strobe follows reset until a new word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module simd_modified_immediate_execute
    import simd_mi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [7:0]        i_imm_byte,
    input  wire logic [3:0]        i_cmode,
    input  wire logic              i_op_bit,
    input  wire logic              i_quad,
    input  wire logic [3:0]        i_vd_field,
    input  wire logic              i_d_high,
    input  wire logic [DataW-1:0]  i_old_first,
    input  wire logic [DataW-1:0]  i_old_second,
    output logic                   o_strobe,
    output logic                   o_undefined,
    output logic [1:0]             o_kind,
    output logic [RegW-1:0]        o_first_index,
    output logic                   o_second_valid,
    output logic [DataW-1:0]       o_new_first,
    output logic [DataW-1:0]       o_new_second
);

    // stage 1: captured instruction word
    logic             r_s1_vld;
    logic [7:0]       r_s1_imm;
    logic [3:0]       r_s1_cmode;
    logic             r_s1_op;
    logic             r_s1_quad;
    logic [3:0]       r_s1_vd;
    logic             r_s1_dh;
    logic [DataW-1:0] r_s1_old1;
    logic [DataW-1:0] r_s1_old2;

    // stage 2: decoded control and expanded immediate
    logic             r_s2_vld;
    t_ctl             r_s2_ctl;
    logic [DataW-1:0] r_s2_imm;
    logic [DataW-1:0] r_s2_old1;
    logic [DataW-1:0] r_s2_old2;

    // stage 3: result word
    logic             r_s3_vld;
    t_ctl             r_s3_ctl;
    logic [DataW-1:0] r_s3_n1;
    logic [DataW-1:0] r_s3_n2;

    t_ctl             dec_ctl;
    logic [DataW-1:0] dec_imm;
    logic [DataW-1:0] n_s3_n1;
    logic [DataW-1:0] n_s3_n2;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_imm   <= i_imm_byte;
            r_s1_cmode <= i_cmode;
            r_s1_op    <= i_op_bit;
            r_s1_quad  <= i_quad;
            r_s1_vd    <= i_vd_field;
            r_s1_dh    <= i_d_high;
            r_s1_old1  <= i_old_first;
            r_s1_old2  <= i_old_second;
        end
    end

    simd_mi_expand u_expand (
        .i_imm_byte (r_s1_imm),
        .i_cmode    (r_s1_cmode),
        .i_op_bit   (r_s1_op),
        .i_quad     (r_s1_quad),
        .i_vd_field (r_s1_vd),
        .i_d_high   (r_s1_dh),
        .o_ctl      (dec_ctl),
        .o_imm      (dec_imm)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_ctl  <= dec_ctl;
            r_s2_imm  <= dec_imm;
            r_s2_old1 <= r_s1_old1;
            r_s2_old2 <= r_s1_old2;
        end
    end

    // combine immediate with old contents; undefined and unused halves are zero
    always_comb begin
        unique case (r_s2_ctl.kind)
            KIND_VMOV: begin
                n_s3_n1 = r_s2_imm;
                n_s3_n2 = r_s2_imm;
            end
            KIND_VMVN: begin
                n_s3_n1 = ~r_s2_imm;
                n_s3_n2 = ~r_s2_imm;
            end
            KIND_VORR: begin
                n_s3_n1 = r_s2_old1 | r_s2_imm;
                n_s3_n2 = r_s2_old2 | r_s2_imm;
            end
            KIND_VBIC: begin
                n_s3_n1 = r_s2_old1 & ~r_s2_imm;
                n_s3_n2 = r_s2_old2 & ~r_s2_imm;
            end
            default: begin
                n_s3_n1 = '0;
                n_s3_n2 = '0;
            end
        endcase
        if (r_s2_ctl.undef) begin
            n_s3_n1 = '0;
        end
        if (!r_s2_ctl.second_valid) begin
            n_s3_n2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_n1  <= n_s3_n1;
            r_s3_n2  <= n_s3_n2;
        end
    end

    assign o_strobe       = r_s3_vld;
    assign o_undefined    = r_s3_ctl.undef;
    assign o_kind         = r_s3_ctl.kind;
    assign o_first_index  = r_s3_ctl.first_index;
    assign o_second_valid = r_s3_ctl.second_valid;
    assign o_new_first    = r_s3_n1;
    assign o_new_second   = r_s3_n2;

`ifndef SYNTHESIS
    // every strobe traces back to an earlier cycle with start high
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 3))
        else $error("strobe without matching input word");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_undefined) |-> (o_new_first == '0 && o_new_second == '0
            && o_kind == KIND_VMOV && o_first_index == '0 && !o_second_valid))
        else $error("undefined word carries non-zero fields");

    a_pair_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_second_valid) |-> !o_first_index[0])
        else $error("register pair starts at odd index");

    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_second_valid) |-> (o_new_second == '0))
        else $error("second value non-zero for single register");
`endif

endmodule

`default_nettype wire

// ===== dv/simd_mi_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// simd_mi_tb_pkg
// Predictor and result scoreboard for the SIMD modified-immediate execute
// testbench: immediate expansion, operation decode and register update.
// ----------------------------------------------------------------------------
package simd_mi_tb_pkg;

    import simd_mi_pkg::*;

    typedef struct packed {
        logic             undef;
        t_kind            kind;
        logic [RegW-1:0]  first_index;
        logic             second_valid;
        logic [DataW-1:0] new_first;
        logic [DataW-1:0] new_second;
    } t_exec_word;

    function automatic logic [63:0] rep32(input logic [31:0] v);
        return {v, v};
    endfunction

    function automatic logic [63:0] rep16(input logic [15:0] v);
        return {v, v, v, v};
    endfunction

    function automatic logic [63:0] expand_modified_imm(input logic op, input logic [3:0] cm,
                                                        input logic [7:0] imm);
        logic [63:0] r;
        r = '0;
        case (cm[3:1])
            3'd0: r = rep32({24'h0, imm});
            3'd1: r = rep32({16'h0, imm, 8'h0});
            3'd2: r = rep32({8'h0, imm, 16'h0});
            3'd3: r = rep32({imm, 24'h0});
            3'd4: r = rep16({8'h0, imm});
            3'd5: r = rep16({imm, 8'h0});
            3'd6: r = cm[0] ? rep32({8'h0, imm, 16'hFFFF}) : rep32({16'h0, imm, 8'hFF});
            default: begin
                if (!cm[0] && !op) begin
                    r = {8{imm}};
                end else if (!cm[0]) begin
                    for (int i = 0; i < 8; i++)
                        r[8*i +: 8] = {8{imm[i]}};
                end else if (!op) begin
                    // single-precision float: a, NOT(b), b x5, cdefgh, zeros
                    r = rep32({imm[7], ~imm[6], {5{imm[6]}}, imm[5:0], 19'h0});
                end else begin
                    // double-precision form, unreachable while cmode 1111 op 1 is undefined
                    r = {imm[7], ~imm[6], {8{imm[6]}}, imm[5:0], 48'h0};
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_exec_word predict_update(input logic [7:0] imm, input logic [3:0] cm,
                                                  input logic op, input logic q,
                                                  input logic [3:0] vd, input logic dh,
                                                  input logic [63:0] o1, input logic [63:0] o2);
        t_exec_word res;
        logic [63:0] e;
        logic [63:0] n1;
        logic [63:0] n2;
        res = '0;
        if ((q && vd[0]) || (cm == 4'hF && op)) begin
            res.undef = 1'b1;
            return res;
        end
        if (cm >= 4'd12)
            res.kind = (op && cm <= 4'd13) ? KIND_VMVN : KIND_VMOV;
        else if (!cm[0])
            res.kind = op ? KIND_VMVN : KIND_VMOV;
        else
            res.kind = op ? KIND_VBIC : KIND_VORR;
        e = expand_modified_imm(op, cm, imm);
        case (res.kind)
            KIND_VMOV: begin n1 = e;        n2 = e;        end
            KIND_VMVN: begin n1 = ~e;       n2 = ~e;       end
            KIND_VORR: begin n1 = o1 | e;   n2 = o2 | e;   end
            default:   begin n1 = o1 & ~e;  n2 = o2 & ~e;  end
        endcase
        res.first_index  = {dh, vd};
        res.second_valid = q;
        res.new_first    = n1;
        res.new_second   = q ? n2 : '0;
        return res;
    endfunction

    class imm_exec_scoreboard;
        t_exec_word pending[$];
        int errors;
        int words_taken;
        int undef_words;
        int per_kind[4];

        function new();
            errors      = 0;
            words_taken = 0;
            undef_words = 0;
            foreach (per_kind[k]) per_kind[k] = 0;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 40)
                $display("ERROR: %s", what);
        endtask

        task note_word(input logic [7:0] imm, input logic [3:0] cm, input logic op,
                       input logic q, input logic [3:0] vd, input logic dh,
                       input logic [63:0] o1, input logic [63:0] o2);
            t_exec_word w;
            w = predict_update(imm, cm, op, q, vd, dh, o1, o2);
            pending.push_back(w);
            words_taken++;
            if (w.undef)
                undef_words++;
            else
                per_kind[w.kind]++;
        endtask

        task check_result(input t_exec_word got);
            t_exec_word want;
            if (pending.size() == 0) begin
                report("result strobed with no word outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.undef !== want.undef)
                report($sformatf("undefined: got %b want %b", got.undef, want.undef));
            if (got.kind !== want.kind)
                report($sformatf("kind: got %0d want %0d", got.kind, want.kind));
            if (got.first_index !== want.first_index)
                report($sformatf("first_index: got %0d want %0d",
                                 got.first_index, want.first_index));
            if (got.second_valid !== want.second_valid)
                report($sformatf("second_valid: got %b want %b",
                                 got.second_valid, want.second_valid));
            if (got.new_first !== want.new_first)
                report($sformatf("new_first: got %h want %h", got.new_first, want.new_first));
            if (got.new_second !== want.new_second)
                report($sformatf("new_second: got %h want %h",
                                 got.new_second, want.new_second));
        endtask

        task check_drained();
            if (pending.size() != 0)
                report($sformatf("%0d expected results never strobed", pending.size()));
        endtask
    endclass

endpackage

// ===== dv/tb_simd_modified_immediate_execute.sv =====
// ----------------------------------------------------------------------------
// tb_simd_modified_immediate_execute
// Self-checking bench for the modified-immediate execute unit: a directed
// sweep of every cmode, corner forms and the undefined encodings, then random words
// under several sender idle patterns, all checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_simd_modified_immediate_execute;

    import simd_mi_pkg::*;
    import simd_mi_tb_pkg::*;

    localparam int ClkPeriod      = 20;
    localparam int RandomWords    = 1650;
    localparam int DrainLimit     = 200;
    localparam int SettleCycles   = 8;     // more than the three-stage pipeline needs to empty
    localparam int WatchdogCycles = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [7:0]       i_imm_byte;
    logic [3:0]       i_cmode;
    logic             i_op_bit;
    logic             i_quad;
    logic [3:0]       i_vd_field;
    logic             i_d_high;
    logic [DataW-1:0] i_old_first;
    logic [DataW-1:0] i_old_second;
    logic             o_strobe;
    logic             o_undefined;
    logic [1:0]       o_kind;
    logic [RegW-1:0]  o_first_index;
    logic             o_second_valid;
    logic [DataW-1:0] o_new_first;
    logic [DataW-1:0] o_new_second;

    imm_exec_scoreboard sb;

    simd_modified_immediate_execute dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_imm_byte     (i_imm_byte),
        .i_cmode        (i_cmode),
        .i_op_bit       (i_op_bit),
        .i_quad         (i_quad),
        .i_vd_field     (i_vd_field),
        .i_d_high       (i_d_high),
        .i_old_first    (i_old_first),
        .i_old_second   (i_old_second),
        .o_strobe       (o_strobe),
        .o_undefined    (o_undefined),
        .o_kind         (o_kind),
        .o_first_index  (o_first_index),
        .o_second_valid (o_second_valid),
        .o_new_first    (o_new_first),
        .o_new_second   (o_new_second)
    );

    always begin
        #(ClkPeriod/2) i_clk = 1'b1;
        #(ClkPeriod/2) i_clk = 1'b0;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #(WatchdogCycles * ClkPeriod);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Monitor, rising edge only. A word taken at this edge is noted before any
    // strobe is checked, so ordering holds even if a word were strobed as it is taken.
    always @(posedge i_clk) begin
        t_exec_word seen;
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_word(i_imm_byte, i_cmode, i_op_bit, i_quad, i_vd_field, i_d_high,
                             i_old_first, i_old_second);
            if (o_strobe) begin
                seen.undef        = o_undefined;
                seen.kind         = t_kind'(o_kind);
                seen.first_index  = o_first_index;
                seen.second_valid = o_second_valid;
                seen.new_first    = o_new_first;
                seen.new_second   = o_new_second;
                sb.check_result(seen);
            end
        end
    end

    // Present one word from the falling edge and hold it until a rising edge
    // finds busy low. start stays high if the next call follows straight on.
    task put_word(input logic [7:0] imm, input logic [3:0] cm, input logic op,
                  input logic q, input logic [3:0] vd, input logic dh,
                  input logic [63:0] o1, input logic [63:0] o2);
        @(negedge i_clk);
        start        <= 1'b1;
        i_imm_byte   <= imm;
        i_cmode      <= cm;
        i_op_bit     <= op;
        i_quad       <= q;
        i_vd_field   <= vd;
        i_d_high     <= dh;
        i_old_first  <= o1;
        i_old_second <= o2;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // idle cycle: start low, junk on the fields that must be ignored
    task rest_cycle();
        @(negedge i_clk);
        start        <= 1'b0;
        i_imm_byte   <= 8'($urandom);
        i_cmode      <= 4'($urandom);
        i_op_bit     <= 1'($urandom);
        i_quad       <= 1'($urandom);
        i_vd_field   <= 4'($urandom);
        i_d_high     <= 1'($urandom);
        i_old_first  <= {$urandom, $urandom};
        i_old_second <= {$urandom, $urandom};
    endtask

    // Every cmode once (op follows cmode bit 1, so the cmode 1111 op 1 undefined
    // form and the byte mask are hit), then the corners: top register numbers, float
    // immediates, odd Vd with Q, and the all-zero / all-ones data.
    task run_directed();
        logic [3:0] c;
        for (int k = 0; k < 16; k++) begin
            c = 4'(k);
            put_word(c[0] ? 8'hFF : 8'h81, c, c[1], c[2], c[2] ? 4'd6 : 4'd9, c[3],
                     c[1] ? '1 : 64'h0, 64'hA5A5_5A5A_0F0F_F0F0);
        end
        put_word(8'h00, 4'hE, 1'b0, 1'b1, 4'hE, 1'b1, '1, '1);
        put_word(8'hFF, 4'hE, 1'b0, 1'b0, 4'hF, 1'b1, 64'h0, '1);
        put_word(8'h00, 4'hF, 1'b0, 1'b1, 4'h2, 1'b0, '1, 64'h0);
        put_word(8'hFF, 4'hF, 1'b0, 1'b0, 4'h1, 1'b1, 64'h0, 64'h0);
        put_word(8'h40, 4'hF, 1'b0, 1'b1, 4'h0, 1'b1, '1, '1);
        put_word(8'h7F, 4'hD, 1'b1, 1'b1, 4'h8, 1'b0, '1, 64'h0);
        put_word(8'h3C, 4'h0, 1'b0, 1'b1, 4'h3, 1'b0, '1, '1);
        put_word(8'hA5, 4'hE, 1'b1, 1'b1, 4'h0, 1'b0, 64'h0, '1);
    endtask

    // Random word, mostly defined: Q usually with an even Vd and cmode 1111
    // op 1 thinned out, so the undefined path is hit without dominating.
    task send_random_word();
        logic [7:0]  imm;
        logic [3:0]  cm;
        logic        op;
        logic        q;
        logic [3:0]  vd;
        logic        dh;
        logic [63:0] o1;
        logic [63:0] o2;
        int          pick;
        pick = $urandom_range(99);
        imm  = 8'($urandom);
        if (pick < 8)
            imm = 8'h00;
        else if (pick < 16)
            imm = 8'hFF;
        cm = 4'($urandom_range(15));
        op = 1'($urandom_range(1));
        q  = 1'($urandom_range(1));
        vd = 4'($urandom_range(15));
        dh = 1'($urandom_range(1));
        if (q && $urandom_range(99) < 85)
            vd[0] = 1'b0;
        if (cm == 4'hF && op && $urandom_range(99) < 60)
            op = 1'b0;
        o1   = {$urandom, $urandom};
        o2   = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 6)
            o1 = '0;
        else if (pick < 12)
            o1 = '1;
        pick = $urandom_range(99);
        if (pick < 6)
            o2 = '0;
        else if (pick < 12)
            o2 = '1;
        put_word(imm, cm, op, q, vd, dh, o1, o2);
    endtask

    initial begin
        int idle_pct[4];
        sb           = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_imm_byte   = '0;
        i_cmode      = '0;
        i_op_bit     = 1'b0;
        i_quad       = 1'b0;
        i_vd_field   = '0;
        i_d_high     = 1'b0;
        i_old_first  = '0;
        i_old_second = '0;

        // Sender idle chance per cycle in each phase. No receiver stall is
        // possible here: results are strobed and cannot be held off, so the
        // "receiver" phase just runs flat out again.
        idle_pct[0] = 0;
        idle_pct[1] = 69;
        idle_pct[2] = 0;
        idle_pct[3] = 22;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < RandomWords / 4; n++) begin
                while ($urandom_range(99) < idle_pct[ph])
                    rest_cycle();
                send_random_word();
            end
        end

        @(negedge i_clk);
        start <= 1'b0;

        // drain, then settle for SettleCycles to catch any stray strobe
        for (int w = 0; w < DrainLimit && sb.pending.size() > 0; w++)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        sb.check_drained();

        $display("Run covered %0d words: vmov %0d, vmvn %0d, vorr %0d, vbic %0d, undefined %0d",
                 sb.words_taken, sb.per_kind[KIND_VMOV], sb.per_kind[KIND_VMVN],
                 sb.per_kind[KIND_VORR], sb.per_kind[KIND_VBIC], sb.undef_words);
        $display("Sender idle patterns 0/69/0/22 percent; %0d mismatches", sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
